// ===== rtl/core/speculative_return_address_stack_top_macros.svh =====
// Assertion macros for the speculative return-address stack.
// Used by the controller and the datapath; needs clk and arst_n in scope.
`ifndef SPECULATIVE_RETURN_ADDRESS_STACK_TOP_MACROS_SVH
`define SPECULATIVE_RETURN_ADDRESS_STACK_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Plain property, checked out of reset
`define SRAS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Condition in this cycle implies the consequent in the next
`define SRAS_ASSERT_NEXT(lbl, cond, conseq, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error(msg);
`else
`define SRAS_ASSERT(lbl, prop, msg)
`define SRAS_ASSERT_NEXT(lbl, cond, conseq, msg)
`endif

`endif

// ===== rtl/core/sras_pkg.sv =====
// Package for the speculative return-address stack.
// Widths, operation codes, default depths and the controller command struct.
`timescale 1ns / 1ps

package sras_pkg;

	localparam int unsigned FUNC_W = 3;
	localparam int unsigned ADDR_W = 64;

	localparam int unsigned DEF_SPEC_DEPTH = 16;
	localparam int unsigned DEF_COMMITTED_DEPTH = 16;

	// request operation codes; the remaining codes are no-ops
	typedef enum logic [FUNC_W-1:0] {
		FN_SPEC_PUSH = 3'd0,
		FN_SPEC_POP  = 3'd1,
		FN_COM_PUSH  = 3'd2,
		FN_COM_POP   = 3'd3,
		FN_RECOVER   = 3'd4
	} func_e_t;

	typedef enum logic {
		ST_IDLE,
		ST_RESULT
	} state_t;

	// one strobe per accepted operation
	typedef struct packed {
		logic sp_push;
		logic sp_pop;
		logic com_push;
		logic com_pop;
		logic recover;
	} cmd_t;

endpackage

// ===== rtl/core/sras_req_if.sv =====
// Request channel of the speculative return-address stack.
// Depends on sras_pkg for field widths.
`timescale 1ns / 1ps

interface sras_req_if;
	import sras_pkg::*;

	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [ADDR_W-1:0] ret_addr;

	modport source (output valid, func, ret_addr, input ready);
	modport sink   (input valid, func, ret_addr, output ready);
endinterface

// ===== rtl/core/sras_rsp_if.sv =====
// Result channel of the speculative return-address stack.
// Depends on sras_pkg for field widths.
`timescale 1ns / 1ps

interface sras_rsp_if;
	import sras_pkg::*;

	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] predicted_addr;
	logic              from_committed;

	modport source (output valid, predicted_addr, from_committed, input ready);
	modport sink   (input valid, predicted_addr, from_committed, output ready);
endinterface

// ===== rtl/core/sras_ctrl.sv =====
// Controller: handshakes, operation decode and result-valid state machine.
// Depends on sras_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "speculative_return_address_stack_top_macros.svh"

module sras_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	input  logic [sras_pkg::FUNC_W-1:0] req_func,
	output logic                       req_ready,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output sras_pkg::cmd_t             cmd
);
	import sras_pkg::*;

	state_t state_q, state_nxt;
	logic   acc;
	logic   is_pop;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// outputs: handshakes and operation strobes
	always_comb begin
		rsp_valid = (state_q == ST_RESULT);
		req_ready = (state_q == ST_IDLE) || rsp_ready;
		acc       = req_valid && req_ready;
		cmd       = '0;
		unique case (func_e_t'(req_func))
			FN_SPEC_PUSH: cmd.sp_push   = acc;
			FN_SPEC_POP:  cmd.sp_pop    = acc;
			FN_COM_PUSH:  cmd.com_push  = acc;
			FN_COM_POP:   cmd.com_pop   = acc;
			FN_RECOVER:   cmd.recover   = acc;
			default:      cmd           = '0;
		endcase
		is_pop = cmd.sp_pop || cmd.com_pop;
	end

	// next state: a pop holds a result until it is taken
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (is_pop) state_nxt = ST_RESULT;
			end
			ST_RESULT: begin
				if (rsp_ready) state_nxt = is_pop ? ST_RESULT : ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// checks
	`SRAS_ASSERT_NEXT(a_pop_gives_result, is_pop, rsp_valid, "pop without result")
	`SRAS_ASSERT(a_strobes_onehot, $onehot0(cmd), "more than one operation strobe")
	`SRAS_ASSERT_NEXT(a_rsp_held, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")
endmodule

// ===== rtl/core/sras_dpath.sv =====
// Datapath: pointers, valid bits, speculative and committed stack memories.
// Depends on sras_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "speculative_return_address_stack_top_macros.svh"

module sras_dpath #(
	parameter int unsigned SPEC_DEPTH      = sras_pkg::DEF_SPEC_DEPTH,
	parameter int unsigned COMMITTED_DEPTH = sras_pkg::DEF_COMMITTED_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sras_pkg::cmd_t              cmd,
	input  logic [sras_pkg::ADDR_W-1:0] ret_addr,
	output logic [sras_pkg::ADDR_W-1:0] predicted_addr,
	output logic                        from_committed
);
	import sras_pkg::*;

	localparam int unsigned SPW = (SPEC_DEPTH > 1) ? $clog2(SPEC_DEPTH) : 1;
	localparam int unsigned CPW = (COMMITTED_DEPTH > 1) ? $clog2(COMMITTED_DEPTH) : 1;
	localparam logic [SPW-1:0] SPEC_LAST = SPW'(SPEC_DEPTH - 1);
	localparam logic [CPW-1:0] COM_LAST  = CPW'(COMMITTED_DEPTH - 1);

	logic [SPW-1:0] spec_top_q, spec_up, spec_dn;
	logic [CPW-1:0] com_top_q, com_up, com_dn;
	logic [CPW-1:0] shadow_q, shadow_up, shadow_dn;
	logic [CPW-1:0] com_raddr;

	logic [SPEC_DEPTH-1:0]      spec_vld_q;
	logic [COMMITTED_DEPTH-1:0] com_vld_q;

	logic [ADDR_W-1:0] spec_mem [SPEC_DEPTH];
	logic [ADDR_W-1:0] com_mem  [COMMITTED_DEPTH];

	logic [ADDR_W-1:0] spec_rd_q, com_rd_q;
	logic              com_rvld_q;
	logic              src_com_q;

	// circular pointer steps
	always_comb begin
		spec_up   = (spec_top_q == SPEC_LAST) ? '0 : spec_top_q + 1'b1;
		spec_dn   = (spec_top_q == '0) ? SPEC_LAST : spec_top_q - 1'b1;
		com_up    = (com_top_q == COM_LAST) ? '0 : com_top_q + 1'b1;
		com_dn    = (com_top_q == '0) ? COM_LAST : com_top_q - 1'b1;
		shadow_up = (shadow_q == COM_LAST) ? '0 : shadow_q + 1'b1;
		shadow_dn = (shadow_q == '0) ? COM_LAST : shadow_q - 1'b1;
		com_raddr = cmd.com_pop ? com_top_q : shadow_q;
	end

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spec_top_q <= '0;
			com_top_q  <= '0;
			shadow_q   <= '0;
		end else begin
			priority if (cmd.sp_push) begin
				spec_top_q <= spec_up;
				shadow_q   <= shadow_up;
			end else if (cmd.sp_pop) begin
				spec_top_q <= spec_dn;
				shadow_q   <= shadow_dn;
			end else if (cmd.com_push) begin
				com_top_q <= com_up;
			end else if (cmd.com_pop) begin
				com_top_q <= com_dn;
			end else if (cmd.recover) begin
				shadow_q <= com_top_q;
			end
		end
	end

	// valid bits; an invalid committed entry reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spec_vld_q <= '0;
			com_vld_q  <= '0;
		end else begin
			if (cmd.recover) begin
				spec_vld_q <= '0;
			end else if (cmd.sp_push) begin
				spec_vld_q[spec_up] <= 1'b1;
			end
			if (cmd.com_push) begin
				com_vld_q[com_up] <= 1'b1;
			end
		end
	end

	// speculative stack memory, registered read
	always_ff @(posedge clk) begin
		if (cmd.sp_push) begin
			spec_mem[spec_up] <= ret_addr;
		end
		if (cmd.sp_pop) begin
			spec_rd_q <= spec_mem[spec_top_q];
		end
	end

	// committed stack memory, registered read at shadow or committed top
	always_ff @(posedge clk) begin
		if (cmd.com_push) begin
			com_mem[com_up] <= ret_addr;
		end
		if (cmd.sp_pop || cmd.com_pop) begin
			com_rd_q   <= com_mem[com_raddr];
			com_rvld_q <= com_vld_q[com_raddr];
			src_com_q  <= cmd.com_pop || !spec_vld_q[spec_top_q];
		end
	end

	// result select
	always_comb begin
		from_committed = src_com_q;
		if (src_com_q) begin
			predicted_addr = com_rvld_q ? com_rd_q : '0;
		end else begin
			predicted_addr = spec_rd_q;
		end
	end

	// checks
	`SRAS_ASSERT_NEXT(a_recover_clears, cmd.recover, spec_vld_q == '0, "valid bits left")
	`SRAS_ASSERT_NEXT(a_recover_shadow, cmd.recover, shadow_q == $past(com_top_q), "shadow not restored")
	`SRAS_ASSERT_NEXT(a_push_marks, cmd.sp_push, spec_vld_q[spec_top_q], "pushed entry not valid")
endmodule

// ===== rtl/core/speculative_return_address_stack_top.sv =====
// Speculative return-address stack, a return-address predictor with a committed backing stack.
// Push, pop and recover requests arrive one per cycle; a pop's result is held in the result
// register until taken, and a new request is accepted in the same cycle the result is taken, so
// the sustained rate is one request per cycle (a pop's result appears in the cycle after accept,
// behind the registered reads of the speculative and committed stack memories). While a
// result waits untaken the request side stalls. No clearing pass follows reset: valid-bit
// flip-flops clear at once on reset, and the speculative ones also on recover. Depends on
// sras_pkg, the two channel interfaces, sras_ctrl and sras_dpath.
`timescale 1ns / 1ps

module speculative_return_address_stack_top #(
	parameter int unsigned SPEC_DEPTH      = sras_pkg::DEF_SPEC_DEPTH,
	parameter int unsigned COMMITTED_DEPTH = sras_pkg::DEF_COMMITTED_DEPTH
) (
	input logic        clk,
	input logic        arst_n,
	sras_req_if.sink   req,
	sras_rsp_if.source rsp
);
	import sras_pkg::*;

	cmd_t cmd;

	// control
	sras_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_func  (req.func),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	// stacks and pointers
	sras_dpath #(
		.SPEC_DEPTH      (SPEC_DEPTH),
		.COMMITTED_DEPTH (COMMITTED_DEPTH)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.ret_addr       (req.ret_addr),
		.predicted_addr (rsp.predicted_addr),
		.from_committed (rsp.from_committed)
	);
endmodule

// ===== tb/speculative_return_address_stack_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the speculative return-address stack top level.
// Needs sras_pkg, sras_req_if, sras_rsp_if and the RTL below speculative_return_address_stack_top.

module speculative_return_address_stack_top_tb;
	import sras_pkg::*;

	localparam int unsigned SPEC_D     = 16;
	localparam int unsigned COM_D      = 16;
	localparam int unsigned CYCLE_CAP  = 200000;
	localparam int unsigned DRAIN_CYC  = 8;
	localparam int unsigned RAND_ITEMS = 1125;

	// codes above recover are no-ops in the block
	localparam logic [FUNC_W-1:0] FN_NOP_LO = FN_RECOVER + 1'b1;
	localparam logic [FUNC_W-1:0] FN_NOP_HI = {FUNC_W{1'b1}};

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic              from_com;
	} pop_result_t;

	// Predicts pop results from accepted requests and checks returned ones
	class ras_scoreboard;
		logic [ADDR_W-1:0] spec_addr[SPEC_D];
		bit                spec_vld[SPEC_D];
		logic [ADDR_W-1:0] com_addr[COM_D];
		int unsigned       spec_ptr, com_ptr, shadow_ptr;
		pop_result_t       pops_due[$];
		int                errors;

		function new();
			foreach (spec_addr[i]) begin
				spec_addr[i] = '0;
				spec_vld[i]  = 1'b0;
			end
			foreach (com_addr[i])
				com_addr[i] = '0;
			spec_ptr   = 0;
			com_ptr    = 0;
			shadow_ptr = 0;
			errors     = 0;
		endfunction

		function int unsigned ring_up(int unsigned p, int unsigned depth);
			return (p + 1 >= depth) ? 0 : p + 1;
		endfunction

		function int unsigned ring_down(int unsigned p, int unsigned depth);
			return (p == 0) ? depth - 1 : p - 1;
		endfunction

		// Apply one accepted request to the stack image
		function void note_request(logic [FUNC_W-1:0] f, logic [ADDR_W-1:0] a);
			pop_result_t r;
			case (f)
				FN_SPEC_PUSH: begin
					spec_ptr           = ring_up(spec_ptr, SPEC_D);
					shadow_ptr         = ring_up(shadow_ptr, COM_D);
					spec_addr[spec_ptr] = a;
					spec_vld[spec_ptr]  = 1'b1;
				end
				FN_SPEC_POP: begin
					// a valid speculative entry wins, else fall back to the shadow slot
					if (spec_vld[spec_ptr]) begin
						r.addr     = spec_addr[spec_ptr];
						r.from_com = 1'b0;
					end else begin
						r.addr     = com_addr[shadow_ptr];
						r.from_com = 1'b1;
					end
					pops_due.push_back(r);
					spec_ptr   = ring_down(spec_ptr, SPEC_D);
					shadow_ptr = ring_down(shadow_ptr, COM_D);
				end
				FN_COM_PUSH: begin
					com_ptr           = ring_up(com_ptr, COM_D);
					com_addr[com_ptr] = a;
				end
				FN_COM_POP: begin
					r.addr     = com_addr[com_ptr];
					r.from_com = 1'b1;
					pops_due.push_back(r);
					com_ptr = ring_down(com_ptr, COM_D);
				end
				FN_RECOVER: begin
					foreach (spec_vld[i])
						spec_vld[i] = 1'b0;
					shadow_ptr = com_ptr;
				end
				default: ;
			endcase
		endfunction

		// Compare a returned pop with the oldest prediction
		function void check_result(logic [ADDR_W-1:0] a, logic c);
			pop_result_t r;
			if (pops_due.size() == 0) begin
				$display("%0t: unexpected result addr=%h from_committed=%b", $time, a, c);
				errors++;
				return;
			end
			r = pops_due.pop_front();
			if (a !== r.addr) begin
				$display("%0t: predicted_addr expected %h actual %h", $time, r.addr, a);
				errors++;
			end
			if (c !== r.from_com) begin
				$display("%0t: from_committed expected %b actual %b", $time, r.from_com, c);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	sras_req_if req ();
	sras_rsp_if rsp ();

	speculative_return_address_stack_top #(
		.SPEC_DEPTH     (SPEC_D),
		.COMMITTED_DEPTH(COM_D)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req.sink),
		.rsp   (rsp.source)
	);

	ras_scoreboard sb = new();
	int unsigned   send_idle_pct = 0;
	int unsigned   ret_stall_pct = 0;
	int unsigned   cycles = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Result side back-pressure
	always @(posedge clk) begin
		rsp.ready <= ($urandom_range(99) >= ret_stall_pct);
	end

	// Results are checked before the request of the same edge is noted
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp.valid && rsp.ready)
				sb.check_result(rsp.predicted_addr, rsp.from_committed);
			if (req.valid && req.ready)
				sb.note_request(req.func, req.ret_addr);
		end
	end

	// Run guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_CAP) begin
			$display("speculative_return_address_stack_top_tb: done, errors");
			$finish;
		end
	end

	// Address mix: extremes, single bits and full random
	function automatic logic [ADDR_W-1:0] pick_addr();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 8)
			return '1;
		else if (r < 16)
			return '0;
		else if (r < 26)
			return {{(ADDR_W-1){1'b0}}, 1'b1} << $urandom_range(ADDR_W-1);
		else
			return {$urandom, $urandom};
	endfunction

	// Drive one request and hold it until accepted
	task automatic issue_req(logic [FUNC_W-1:0] f, logic [ADDR_W-1:0] a);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid    <= 1'b1;
		req.func     <= f;
		req.ret_addr <= a;
		do
			@(posedge clk);
		while (!req.ready);
	endtask

	task automatic directed_ops();
		issue_req(FN_SPEC_POP, '1);           // empty stack: committed zero
		issue_req(FN_COM_POP, '0);            // committed underflow wraps
		issue_req(FN_COM_PUSH, '1);
		issue_req(FN_COM_PUSH, 64'h0123_4567_89ab_cdef);
		issue_req(FN_SPEC_PUSH, '0);
		issue_req(FN_SPEC_PUSH, '1);
		issue_req(FN_SPEC_PUSH, 64'h8000_0000_0000_0000);
		issue_req(FN_SPEC_POP, '0);
		issue_req(FN_SPEC_POP, '0);
		issue_req(FN_SPEC_POP, '0);
		issue_req(FN_SPEC_POP, '1);           // past the pushes: committed fallback
		issue_req(FN_SPEC_POP, '0);
		issue_req(FN_RECOVER, '1);
		issue_req(FN_SPEC_POP, '0);
		issue_req(FN_NOP_LO, '1);
		issue_req(FN_NOP_LO + 1'b1, 64'h5555_5555_5555_5555);
		issue_req(FN_NOP_HI, 64'haaaa_aaaa_aaaa_aaaa);
		issue_req(FN_COM_PUSH, 64'hfeed_0000_0000_0001);
		issue_req(FN_SPEC_PUSH, 64'h0000_0000_0000_0001);
		issue_req(FN_COM_POP, '0);
		issue_req(FN_SPEC_POP, '0);
		issue_req(FN_RECOVER, '0);
		issue_req(FN_SPEC_POP, '0);
		issue_req(FN_COM_POP, '0);
	endtask

	// Mostly call/return shaped traffic, some noise
	task automatic random_ops(int unsigned n);
		int unsigned done_cnt;
		int unsigned r, k, j;
		done_cnt = 0;
		while (done_cnt < n) begin
			r = $urandom_range(99);
			if (r < 35) begin
				// call depth burst, returns may overrun into the committed side
				k = $urandom_range(20, 1);
				j = $urandom_range(k + 2);
				repeat (k) issue_req(FN_SPEC_PUSH, pick_addr());
				repeat (j) issue_req(FN_SPEC_POP, pick_addr());
				done_cnt += k + j;
			end else if (r < 55) begin
				k = $urandom_range(6, 1);
				j = $urandom_range(k + 1);
				repeat (k) issue_req(FN_COM_PUSH, pick_addr());
				repeat (j) issue_req(FN_COM_POP, pick_addr());
				done_cnt += k + j;
			end else if (r < 70) begin
				// mispredict: flush, then return through the committed stack
				j = $urandom_range(4);
				issue_req(FN_RECOVER, pick_addr());
				repeat (j) issue_req(FN_SPEC_POP, pick_addr());
				done_cnt += 1 + j;
			end else if (r < 96) begin
				issue_req(FUNC_W'($urandom_range(FN_RECOVER, FN_SPEC_PUSH)), pick_addr());
				done_cnt++;
			end else begin
				issue_req(FUNC_W'($urandom_range(FN_NOP_HI, FN_NOP_LO)), pick_addr());
			end
		end
	endtask

	initial begin
		int unsigned ph;
		arst_n       = 1'b0;
		req.valid    = 1'b0;
		req.func     = FN_SPEC_PUSH;
		req.ret_addr = '0;
		rsp.ready    = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_ops();

		// idle phases: none, sender gaps, receiver stalls, both light
		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  ret_stall_pct = 0;  end
				1: begin send_idle_pct = 68; ret_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  ret_stall_pct = 68; end
				default: begin send_idle_pct = 13; ret_stall_pct = 13; end
			endcase
			random_ops(RAND_ITEMS / 4);
		end
		req.valid <= 1'b0;

		while (sb.pops_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		if (sb.errors == 0)
			$display("speculative_return_address_stack_top_tb: done, clean");
		else
			$display("speculative_return_address_stack_top_tb: done, errors");
		$finish;
	end

endmodule
